[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define HLEP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define HLEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/hlep_pkg.sv]
// ----------------------------------------------------------------------------
// hlep_pkg
// Types, constants and helpers for the letter encoder and word packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hlep_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FREE_W      = $clog2(WORD_BITS + 1);
  localparam int CODE_W      = 16;
  localparam int LEN_W       = 5;
  localparam int SYM_W       = 5;
  localparam int CHAR_W      = 8;
  localparam int NUM_SYMBOLS = 27;   // terminator plus a..z

  localparam int ALPHABET_SIZE_DEF = 27;
  localparam int MAX_CODE_LEN_DEF  = 16;

  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_CNT_W = 2;

  localparam logic [FREE_W-1:0] WORD_BITS_F = FREE_W'(WORD_BITS);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] LOWER_BASE = 8'd96;
  localparam logic [CHAR_W-1:0] UPPER_BASE = 8'd64;

  typedef struct packed {
    logic [WORD_BITS-1:0] packed_word;
    logic                 last_word;
    logic                 bad_character;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;   // beats produced by this item, 0 to 2
    res_t       r0;
    res_t       r1;
  } pk_out_t;

  typedef struct packed {
    logic             ok;
    logic             term;
    logic [SYM_W-1:0] idx;
  } fold_t;

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [FREE_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    m = '1;
    if (n < WORD_BITS_F) begin
      m = ~({WORD_BITS{1'b1}} << n);
    end
    return m;
  endfunction

  function automatic fold_t fold_char(input logic [CHAR_W-1:0] ch);
    fold_t             f;
    logic [CHAR_W-1:0] d;
    f.ok   = 1'b1;
    f.term = 1'b0;
    d      = '0;
    if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      d = ch - LOWER_BASE;
    end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      d = ch - UPPER_BASE;
    end else if (ch == CH_NUL) begin
      f.term = 1'b1;
    end else begin
      f.ok = 1'b0;
    end
    f.idx = d[SYM_W-1:0];
    return f;
  endfunction

endpackage

`default_nettype wire

[rtl/hlep_table.sv]
// ----------------------------------------------------------------------------
// hlep_table
// Code and length register file, one write port, one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hlep_table #(
  parameter int ALPHABET_SIZE = hlep_pkg::ALPHABET_SIZE_DEF,
  parameter int MAX_CODE_LEN  = hlep_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [hlep_pkg::SYM_W-1:0]  waddr,
  input  wire logic [hlep_pkg::CODE_W-1:0] wcode,
  input  wire logic [hlep_pkg::LEN_W-1:0]  wlen,
  input  wire logic [hlep_pkg::SYM_W-1:0]  raddr,
  output logic      [hlep_pkg::CODE_W-1:0] rcode,
  output logic      [hlep_pkg::LEN_W-1:0]  rlen
);
  import hlep_pkg::*;

  // entries past the letters are never read
  localparam int DEPTH = (ALPHABET_SIZE < NUM_SYMBOLS) ? ALPHABET_SIZE : NUM_SYMBOLS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LIM   = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
  localparam logic [FREE_W-1:0] LIM_F = FREE_W'(LIM);

  logic [CODE_W-1:0] code_r [DEPTH];
  logic [LEN_W-1:0]  len_r  [DEPTH];
  logic [LEN_W-1:0]  wlen_clamped;

  always_comb begin
    wlen_clamped = wlen;
    if ({1'b0, wlen} > LIM_F) begin
      wlen_clamped = LIM_F[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we && (int'(waddr) < DEPTH)) begin
      code_r[waddr[IDX_W-1:0]] <= wcode;
      len_r[waddr[IDX_W-1:0]]  <= wlen_clamped;
    end
  end

  always_comb begin
    rcode = '0;
    rlen  = '0;
    if (int'(raddr) < DEPTH) begin
      rcode = code_r[raddr[IDX_W-1:0]];
      rlen  = len_r[raddr[IDX_W-1:0]];
    end
  end

endmodule

`default_nettype wire

[rtl/hlep_pack.sv]
// ----------------------------------------------------------------------------
// hlep_pack
// Word packer: running word and free-bit count, result beats per item.
// ----------------------------------------------------------------------------
`default_nettype none

module hlep_pack #(
  parameter int ALPHABET_SIZE = hlep_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        op,
  input  wire logic [hlep_pkg::CHAR_W-1:0] character,
  input  wire logic [hlep_pkg::CODE_W-1:0] rcode,
  input  wire logic [hlep_pkg::LEN_W-1:0]  rlen,
  output hlep_pkg::pk_out_t                pk,
  output logic      [hlep_pkg::FREE_W-1:0] free_bits
);
  import hlep_pkg::*;

  logic [WORD_BITS-1:0] buf_r, buf_nxt;
  logic [FREE_W-1:0]    free_r, free_nxt;

  fold_t                f;
  logic                 bad, fits, ends;
  logic [FREE_W-1:0]    len6, sh_fit, rem;
  logic [WORD_BITS-1:0] code_w, buf_fit, word_sp, buf_sp;

  always_comb begin
    f      = fold_char(character);
    bad    = !f.ok || (int'(f.idx) >= ALPHABET_SIZE);
    len6   = {1'b0, rlen};
    code_w = WORD_BITS'(rcode);
    fits   = len6 < free_r;
    // code fits: place it just below the bits already held
    sh_fit  = free_r - len6;
    buf_fit = buf_r | ((code_w & low_mask(len6)) << sh_fit);
    // code overflows: top part closes the word, rest opens the next
    rem     = len6 - free_r;
    word_sp = buf_r | ((code_w >> rem) & low_mask(free_r));
    buf_sp  = (rem != '0) ? ((code_w & low_mask(rem)) << (WORD_BITS_F - rem)) : '0;
    ends    = f.term && (rem == '0);
  end

  always_comb begin
    pk.r1 = '{packed_word: buf_sp, last_word: 1'b1, bad_character: 1'b0};
    if (bad) begin
      pk.r0 = '{packed_word: '0, last_word: 1'b0, bad_character: 1'b1};
    end else if (fits) begin
      pk.r0 = '{packed_word: buf_fit, last_word: 1'b1, bad_character: 1'b0};
    end else begin
      pk.r0 = '{packed_word: word_sp, last_word: ends, bad_character: 1'b0};
    end

    if (op == OP_LOAD) begin
      pk.cnt = 2'd0;
    end else if (bad) begin
      pk.cnt = 2'd1;
    end else if (fits) begin
      pk.cnt = f.term ? 2'd1 : 2'd0;
    end else begin
      pk.cnt = (f.term && !ends) ? 2'd2 : 2'd1;
    end
  end

  always_comb begin
    buf_nxt  = buf_r;
    free_nxt = free_r;
    if (en && (op == OP_ENCODE) && !bad) begin
      if (f.term) begin
        buf_nxt  = '0;
        free_nxt = WORD_BITS_F;
      end else if (fits) begin
        buf_nxt  = buf_fit;
        free_nxt = free_r - len6;
      end else begin
        buf_nxt  = buf_sp;
        free_nxt = WORD_BITS_F - rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= '0;
      free_r <= WORD_BITS_F;
    end else begin
      buf_r  <= buf_nxt;
      free_r <= free_nxt;
    end
  end

  assign free_bits = free_r;

endmodule

`default_nettype wire

[rtl/hlep_outq.sv]
// ----------------------------------------------------------------------------
// hlep_outq
// Three-entry result queue; takes up to two beats, gives one per cycle on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module hlep_outq (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [1:0]                      push_cnt,
  input  hlep_pkg::res_t                       push_r0,
  input  hlep_pkg::res_t                       push_r1,
  input  wire logic                            pop,
  output hlep_pkg::res_t                       head,
  output logic      [hlep_pkg::OUTQ_CNT_W-1:0] count
);
  import hlep_pkg::*;

  res_t                  q_r   [OUTQ_DEPTH];
  res_t                  q_nxt [OUTQ_DEPTH];
  logic [OUTQ_CNT_W-1:0] cnt_r, cnt_nxt;

  // pushes only come while cnt_r <= 1, so cnt and cnt + 1 stay in range
  always_comb begin
    logic [OUTQ_CNT_W-1:0] c;
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    c = cnt_r;
    if (pop) begin
      for (int i = 0; i < OUTQ_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      c = c - 1'b1;
    end
    if (push_cnt != 2'd0) begin
      q_nxt[c] = push_r0;
    end
    if (push_cnt == 2'd2) begin
      q_nxt[c + 1'b1] = push_r1;
    end
    cnt_nxt = c + push_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign head  = q_r[0];
  assign count = cnt_r;

endmodule

`default_nettype wire

[rtl/huffman_letter_encoder_packer_unit.sv]
// ----------------------------------------------------------------------------
// huffman_letter_encoder_packer_unit
// Letter encoder: table lookup, MSB-first packing into 32-bit words.
// ----------------------------------------------------------------------------
//
//   channel | dir | beat contents
//   --------+-----+------------------------------------------------------
//   in_     | in  | operation, symbol_index, code_bits, code_length, character
//   out_    | out | packed_word, last_word, bad_character
//
// One item per cycle enters unless stalled; its first beat passes s1 and the
// queue. Loads give no beat, letters none or one, a terminator up to two; the
// queue drains one beat per cycle unless stalled; s1 waits after two-beat items.
// Reset clears the pipeline, the queue and the running word (32 bits free);
// the code table keeps its contents and is undefined until loaded.
// Output stalls back up through the three-entry queue into in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module huffman_letter_encoder_packer_unit #(
  parameter int ALPHABET_SIZE = hlep_pkg::ALPHABET_SIZE_DEF,
  parameter int MAX_CODE_LEN  = hlep_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input beats
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_operation,
  input  wire logic [hlep_pkg::SYM_W-1:0]     in_symbol_index,
  input  wire logic [hlep_pkg::CODE_W-1:0]    in_code_bits,
  input  wire logic [hlep_pkg::LEN_W-1:0]     in_code_length,
  input  wire logic [hlep_pkg::CHAR_W-1:0]    in_character,
  // result beats
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [hlep_pkg::WORD_BITS-1:0] out_packed_word,
  output logic                                out_last_word,
  output logic                                out_bad_character
);
  import hlep_pkg::*;

  // input register stage
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_op_r;
  logic [SYM_W-1:0]  s1_sym_r;
  logic [CODE_W-1:0] s1_code_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic [CHAR_W-1:0] s1_char_r;

  logic                  in_fire, fire;
  logic [OUTQ_CNT_W-1:0] q_cnt;
  logic [CODE_W-1:0]     tbl_code;
  logic [LEN_W-1:0]      tbl_len;
  logic [FREE_W-1:0]     free_bits;
  pk_out_t               pk;
  res_t                  head;
  fold_t                 s1_fold;

  // s1 retires once the queue has room for two beats; count is registered,
  // so in_ready never depends on out_ready
  assign fire     = s1_valid_r && (q_cnt <= OUTQ_CNT_W'(1));
  assign in_ready = !s1_valid_r || fire;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_operation;
      s1_sym_r  <= in_symbol_index;
      s1_code_r <= in_code_bits;
      s1_len_r  <= in_code_length;
      s1_char_r <= in_character;
    end
  end

  assign s1_fold = fold_char(s1_char_r);

  // a load written here is seen by the next character onwards
  hlep_table #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_CODE_LEN  (MAX_CODE_LEN)
  ) u_table (
    .clk   (clk),
    .we    (fire && (s1_op_r == OP_LOAD)),
    .waddr (s1_sym_r),
    .wcode (s1_code_r),
    .wlen  (s1_len_r),
    .raddr (s1_fold.idx),
    .rcode (tbl_code),
    .rlen  (tbl_len)
  );

  hlep_pack #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (fire),
    .op        (s1_op_r),
    .character (s1_char_r),
    .rcode     (tbl_code),
    .rlen      (tbl_len),
    .pk        (pk),
    .free_bits (free_bits)
  );

  hlep_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (fire ? pk.cnt : 2'd0),
    .push_r0  (pk.r0),
    .push_r1  (pk.r1),
    .pop      (out_valid && out_ready),
    .head     (head),
    .count    (q_cnt)
  );

  assign out_valid         = (q_cnt != '0);
  assign out_packed_word   = head.packed_word;
  assign out_last_word     = head.last_word;
  assign out_bad_character = head.bad_character;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `HLEP_ASSERT_NEXT(a_term_clears_word,
    fire && (s1_op_r == OP_ENCODE) && (s1_char_r == CH_NUL),
    free_bits == WORD_BITS_F, "terminator did not restart the word")
  `HLEP_ASSERT_NEXT(a_bad_keeps_state,
    fire && (s1_op_r == OP_ENCODE) && pk.r0.bad_character,
    $stable(free_bits), "rejected character changed the packer")
  `HLEP_ASSERT_SAME(a_bad_beat_clean,
    out_valid && out_bad_character,
    !out_last_word && (out_packed_word == '0), "error beat carries data")

endmodule

`default_nettype wire
